FILE: src/lsrc_pkg.sv
// Package for the latency sample ring: sizes, codes and shared types.
// Used by lsrc_entry_store, the top level and the testbench; depends on nothing.
`default_nettype none
package lsrc_pkg;
   localparam int RING_DEPTH = 64;
   localparam int LOOKBACK = 8;
   localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CAP_W = $clog2(RING_DEPTH + 1);
   localparam int LB_W = $clog2(LOOKBACK + 1);
   localparam logic [6:0] RING_SIZE_RESET = 7'd64;
   localparam logic [15:0] CARRIED_MAX = 16'hFFFF;

   localparam logic [7:0] CSR_RING_SIZE = 8'd0;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_INTAKE = 3'd1,
      MODE_TAKE = 3'd2,
      MODE_APPLY = 3'd3,
      MODE_REDRAW = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] carried;
      logic applied;
      logic redrawn;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear;
      logic [ADDR_W-1:0] rd_addr;
      logic we;
      logic [ADDR_W-1:0] wr_addr;
      entry_type wr_data;
   } store_req_type;
endpackage
`default_nettype wire

FILE: src/lsrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; has no dependencies.
`default_nettype none
module lsrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: src/lsrc_entry_store.sv
// Ring entry store: the entry RAM plus one valid bit per entry.
// An entry that is not valid reads as zero. Depends on lsrc_pkg and lsrc_ram.
`default_nettype none
module lsrc_entry_store (
   input wire logic clock,
   input wire logic reset,
   input wire lsrc_pkg::store_req_type req,
   output lsrc_pkg::entry_type rd_entry
);
   logic [lsrc_pkg::RING_DEPTH-1:0] valid_ff;
   logic [lsrc_pkg::RING_DEPTH-1:0] valid_in;
   logic rd_valid_ff;
   logic [lsrc_pkg::ENTRY_W-1:0] raw;

   lsrc_ram #(
      .WIDTH(lsrc_pkg::ENTRY_W),
      .DEPTH(lsrc_pkg::RING_DEPTH)
   ) u_ram (
      .clock(clock),
      .we(req.we),
      .wr_addr(req.wr_addr),
      .wr_data(req.wr_data),
      .rd_addr(req.rd_addr),
      .rd_data(raw)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.we) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rd_valid_ff <= valid_ff[req.rd_addr] & ~req.clear;
      end
   end

   assign rd_entry = rd_valid_ff ? lsrc_pkg::entry_type'(raw) : '0;
endmodule
`default_nettype wire

FILE: src/latency_sample_ring_coalescer.sv
// Top level of the latency sample ring: command sequencer, mailbox and counters.
// Depends on lsrc_pkg and lsrc_entry_store.
//
// Clear, take and unused modes answer in the cycle after start. Intake and apply
// read one ring entry through the LOOK and CHECK states and then answer. Redraw
// reads up to LOOKBACK entries, each through LOOK and CHECK on the single read
// port of the entry RAM. Busy is high while a request is in work. Each response
// is shown for one cycle with rsp_valid high; the receiver cannot stall it.
`default_nettype none
module latency_sample_ring_coalescer (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [2:0] req_mode,
   input wire logic [31:0] req_cmd_seq,
   input wire logic [15:0] req_cmd_h,
   input wire logic [15:0] req_cmd_v,
   input wire logic [7:0] req_cmd_op,
   input wire logic [31:0] req_cmd_arg,
   input wire logic [31:0] req_time_now,
   input wire logic [5:0] req_slot,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [7:0] csr_index,
   input wire logic [7:0] csr_wdata,
   output logic rsp_valid,
   output logic [5:0] rsp_slot_used,
   output logic rsp_took,
   output logic [31:0] rsp_box_seq,
   output logic [31:0] rsp_box_arrival,
   output logic [15:0] rsp_box_h,
   output logic [15:0] rsp_box_v,
   output logic [7:0] rsp_box_op,
   output logic [31:0] rsp_box_arg,
   output logic [5:0] rsp_box_slot,
   output logic [4:0] rsp_events
);
   localparam int AW = lsrc_pkg::ADDR_W;
   localparam int CW = lsrc_pkg::CAP_W;
   localparam int LW = lsrc_pkg::LB_W;

   lsrc_pkg::state_type state_ff, state_in;
   lsrc_pkg::mode_type mode_ff, mode_in;
   lsrc_pkg::store_req_type sreq;
   lsrc_pkg::entry_type rd_entry;

   logic [6:0] ring_size_ff, ring_size_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0] high_seq_ff, high_seq_in;
   logic mb_pending_ff, mb_pending_in;
   logic [31:0] mb_seq_ff, mb_seq_in, mb_arrival_ff, mb_arrival_in, mb_arg_ff, mb_arg_in;
   logic [15:0] mb_h_ff, mb_h_in, mb_v_ff, mb_v_in;
   logic [7:0] mb_op_ff, mb_op_in;
   logic [AW-1:0] mb_slot_ff, mb_slot_in;

   logic [31:0] seq_ff, seq_in, now_ff, now_in, arg_ff, arg_in;
   logic [15:0] h_ff, h_in, v_ff, v_in;
   logic [7:0] op_ff, op_in;
   logic [AW-1:0] addr_ff, addr_in, idx_ff, idx_in;
   logic slot_ok_ff, slot_ok_in;
   logic [LW-1:0] step_ff, step_in;
   logic [4:0] ev_ff, ev_in;

   logic rsp_valid_ff, rsp_valid_in, took_ff, took_in;
   logic [5:0] slot_used_ff, slot_used_in, box_slot_ff, box_slot_in;
   logic [31:0] box_seq_ff, box_seq_in, box_arrival_ff, box_arrival_in;
   logic [31:0] box_arg_ff, box_arg_in;
   logic [15:0] box_h_ff, box_h_in, box_v_ff, box_v_in;
   logic [7:0] box_op_ff, box_op_in;
   logic [4:0] events_ff, events_in;

   logic [CW-1:0] cap;
   logic [AW-1:0] pos;
   logic [AW-1:0] last_addr;
   logic [AW-1:0] prev_addr;
   logic [15:0] carried;
   logic accept;

   lsrc_entry_store u_store (
      .clock(clock),
      .reset(reset),
      .req(sreq),
      .rd_entry(rd_entry)
   );

   always_comb begin
      if (ring_size_ff == 7'd0) begin
         cap = CW'(1);
      end else if (32'(ring_size_ff) > 32'(lsrc_pkg::RING_DEPTH)) begin
         cap = CW'(lsrc_pkg::RING_DEPTH);
      end else begin
         cap = CW'(ring_size_ff);
      end
      pos = (CW'(wpos_ff) < cap) ? wpos_ff : '0;
      last_addr = AW'(cap - CW'(1));
      prev_addr = (addr_ff == '0) ? last_addr : addr_ff - AW'(1);
      if (rd_entry.seq == mb_seq_ff) begin
         carried = (rd_entry.carried == lsrc_pkg::CARRIED_MAX) ?
                   lsrc_pkg::CARRIED_MAX : rd_entry.carried + 16'd1;
      end else begin
         carried = 16'd1;
      end
   end

   assign accept = start & ~busy;
   assign busy = (state_ff != lsrc_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign ring_size_in = (csr_valid && csr_index == lsrc_pkg::CSR_RING_SIZE) ?
                         csr_wdata[6:0] : ring_size_ff;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      wpos_in = wpos_ff;
      fill_in = fill_ff;
      high_seq_in = high_seq_ff;
      mb_pending_in = mb_pending_ff;
      mb_seq_in = mb_seq_ff;
      mb_arrival_in = mb_arrival_ff;
      mb_h_in = mb_h_ff;
      mb_v_in = mb_v_ff;
      mb_op_in = mb_op_ff;
      mb_arg_in = mb_arg_ff;
      mb_slot_in = mb_slot_ff;
      seq_in = seq_ff;
      now_in = now_ff;
      arg_in = arg_ff;
      h_in = h_ff;
      v_in = v_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      idx_in = idx_ff;
      slot_ok_in = slot_ok_ff;
      step_in = step_ff;
      ev_in = ev_ff;
      rsp_valid_in = 1'b0;
      took_in = 1'b0;
      slot_used_in = '0;
      box_seq_in = '0;
      box_arrival_in = '0;
      box_h_in = '0;
      box_v_in = '0;
      box_op_in = '0;
      box_arg_in = '0;
      box_slot_in = '0;
      events_in = '0;
      sreq = '0;
      sreq.rd_addr = addr_ff;

      unique case (state_ff)
         lsrc_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = lsrc_pkg::mode_type'(req_mode);
               seq_in = req_cmd_seq;
               now_in = req_time_now;
               arg_in = req_cmd_arg;
               h_in = req_cmd_h;
               v_in = req_cmd_v;
               op_in = req_cmd_op;
               ev_in = '0;
               step_in = LW'(1);
               case (req_mode)
                  lsrc_pkg::MODE_CLEAR: begin
                     sreq.clear = 1'b1;
                     wpos_in = '0;
                     fill_in = '0;
                     high_seq_in = '0;
                     mb_pending_in = 1'b0;
                     mb_seq_in = '0;
                     mb_arrival_in = '0;
                     mb_h_in = '0;
                     mb_v_in = '0;
                     mb_op_in = '0;
                     mb_arg_in = '0;
                     mb_slot_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  lsrc_pkg::MODE_INTAKE: begin
                     idx_in = pos;
                     wpos_in = (CW'(pos) + CW'(1) == cap) ? '0 : pos + AW'(1);
                     if (fill_ff >= cap) begin
                        ev_in[1] = 1'b1;
                     end else begin
                        fill_in = fill_ff + CW'(1);
                     end
                     ev_in[0] = mb_pending_ff;
                     addr_in = mb_slot_ff;
                     state_in = lsrc_pkg::ST_LOOK;
                  end
                  lsrc_pkg::MODE_TAKE: begin
                     rsp_valid_in = 1'b1;
                     if (mb_pending_ff) begin
                        took_in = 1'b1;
                        box_seq_in = mb_seq_ff;
                        box_arrival_in = mb_arrival_ff;
                        box_h_in = mb_h_ff;
                        box_v_in = mb_v_ff;
                        box_op_in = mb_op_ff;
                        box_arg_in = mb_arg_ff;
                        box_slot_in = 6'(mb_slot_ff);
                        mb_pending_in = 1'b0;
                     end
                  end
                  lsrc_pkg::MODE_APPLY: begin
                     if (req_cmd_seq < high_seq_ff) begin
                        ev_in[2] = 1'b1;
                     end else begin
                        high_seq_in = req_cmd_seq;
                     end
                     slot_ok_in = (32'(req_slot) < 32'(lsrc_pkg::RING_DEPTH));
                     addr_in = AW'(req_slot);
                     state_in = lsrc_pkg::ST_LOOK;
                  end
                  lsrc_pkg::MODE_REDRAW: begin
                     addr_in = (pos == '0) ? last_addr : pos - AW'(1);
                     state_in = lsrc_pkg::ST_LOOK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lsrc_pkg::ST_LOOK: begin
            state_in = lsrc_pkg::ST_CHECK;
         end
         lsrc_pkg::ST_CHECK: begin
            state_in = lsrc_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            events_in = ev_ff;
            case (mode_ff)
               lsrc_pkg::MODE_INTAKE: begin
                  sreq.we = 1'b1;
                  sreq.wr_addr = idx_ff;
                  sreq.wr_data.seq = seq_ff;
                  sreq.wr_data.carried = mb_pending_ff ? carried : 16'd0;
                  sreq.wr_data.applied = 1'b0;
                  sreq.wr_data.redrawn = 1'b0;
                  mb_pending_in = 1'b1;
                  mb_seq_in = seq_ff;
                  mb_arrival_in = now_ff;
                  mb_h_in = h_ff;
                  mb_v_in = v_ff;
                  mb_op_in = op_ff;
                  mb_arg_in = arg_ff;
                  mb_slot_in = idx_ff;
                  slot_used_in = 6'(idx_ff);
               end
               lsrc_pkg::MODE_APPLY: begin
                  if (slot_ok_ff && rd_entry.seq == seq_ff) begin
                     sreq.we = 1'b1;
                     sreq.wr_addr = addr_ff;
                     sreq.wr_data = rd_entry;
                     sreq.wr_data.applied = 1'b1;
                     events_in[3] = 1'b1;
                  end
               end
               default: begin
                  if (!rd_entry.redrawn && rd_entry.applied) begin
                     sreq.we = 1'b1;
                     sreq.wr_addr = addr_ff;
                     sreq.wr_data = rd_entry;
                     sreq.wr_data.redrawn = 1'b1;
                     events_in[4] = 1'b1;
                  end else if (!rd_entry.redrawn && 32'(step_ff) < 32'(lsrc_pkg::LOOKBACK)
                               && 32'(step_ff) < 32'(cap)) begin
                     rsp_valid_in = 1'b0;
                     events_in = '0;
                     step_in = step_ff + LW'(1);
                     addr_in = prev_addr;
                     state_in = lsrc_pkg::ST_LOOK;
                  end
               end
            endcase
         end
         default: begin
            state_in = lsrc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsrc_pkg::ST_IDLE;
         mode_ff <= lsrc_pkg::MODE_CLEAR;
         ring_size_ff <= lsrc_pkg::RING_SIZE_RESET;
         wpos_ff <= '0;
         fill_ff <= '0;
         high_seq_ff <= '0;
         mb_pending_ff <= 1'b0;
         mb_seq_ff <= '0;
         mb_arrival_ff <= '0;
         mb_h_ff <= '0;
         mb_v_ff <= '0;
         mb_op_ff <= '0;
         mb_arg_ff <= '0;
         mb_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         ring_size_ff <= ring_size_in;
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
         high_seq_ff <= high_seq_in;
         mb_pending_ff <= mb_pending_in;
         mb_seq_ff <= mb_seq_in;
         mb_arrival_ff <= mb_arrival_in;
         mb_h_ff <= mb_h_in;
         mb_v_ff <= mb_v_in;
         mb_op_ff <= mb_op_in;
         mb_arg_ff <= mb_arg_in;
         mb_slot_ff <= mb_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      now_ff <= now_in;
      arg_ff <= arg_in;
      h_ff <= h_in;
      v_ff <= v_in;
      op_ff <= op_in;
      addr_ff <= addr_in;
      idx_ff <= idx_in;
      slot_ok_ff <= slot_ok_in;
      step_ff <= step_in;
      ev_ff <= ev_in;
      took_ff <= took_in;
      slot_used_ff <= slot_used_in;
      box_seq_ff <= box_seq_in;
      box_arrival_ff <= box_arrival_in;
      box_h_ff <= box_h_in;
      box_v_ff <= box_v_in;
      box_op_ff <= box_op_in;
      box_arg_ff <= box_arg_in;
      box_slot_ff <= box_slot_in;
      events_ff <= events_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot_used = slot_used_ff;
   assign rsp_took = took_ff;
   assign rsp_box_seq = box_seq_ff;
   assign rsp_box_arrival = box_arrival_ff;
   assign rsp_box_h = box_h_ff;
   assign rsp_box_v = box_v_ff;
   assign rsp_box_op = box_op_ff;
   assign rsp_box_arg = box_arg_ff;
   assign rsp_box_slot = box_slot_ff;
   assign rsp_events = events_ff;
endmodule
`default_nettype wire

FILE: verif/latency_sample_ring_coalescer_tb.sv
// Self-checking testbench for latency_sample_ring_coalescer: a directed table, then random
// phases over several ring sizes and click opcodes, checked against a ring predictor
// (typed table rows against a fixed outcome). Depends on lsrc_pkg and the block's RTL.
`default_nettype none
module latency_sample_ring_coalescer_tb;
   import lsrc_pkg::*;

   localparam logic [7:0] CSR_CLICK_OPCODE = 8'd1;
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam logic [4:0] EV_COALESCED = 5'd1;
   localparam logic [4:0] EV_DROPPED = 5'd2;
   localparam logic [4:0] EV_BACKWARDS = 5'd4;
   localparam logic [4:0] EV_STAMPED = 5'd8;
   localparam logic [4:0] EV_REDRAWN = 5'd16;
   localparam logic [4:0] FL_CLICK = 5'd1;
   localparam logic [4:0] FL_COALESCED = 5'd2;
   localparam logic [4:0] FL_APPLIED = 5'd4;
   localparam logic [4:0] FL_BACKWARDS = 5'd8;
   localparam logic [4:0] FL_REDRAWN = 5'd16;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * LOOKBACK + 8;

   typedef struct packed {
      logic [2:0] mode;
      logic [31:0] seq;
      logic [15:0] h;
      logic [15:0] v;
      logic [7:0] op;
      logic [31:0] arg;
      logic [31:0] now;
      logic [5:0] slot;
   } request_type;

   typedef struct packed {
      logic [5:0] slot_used;
      logic took;
      logic [31:0] seq;
      logic [31:0] arrival;
      logic [15:0] h;
      logic [15:0] v;
      logic [7:0] op;
      logic [31:0] arg;
      logic [5:0] slot;
      logic [4:0] events;
   } outcome_type;

   typedef struct {
      request_type req;
      bit typed;
      outcome_type outcome;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_mode = '0;
   logic [31:0] req_cmd_seq = '0;
   logic [15:0] req_cmd_h = '0;
   logic [15:0] req_cmd_v = '0;
   logic [7:0] req_cmd_op = '0;
   logic [31:0] req_cmd_arg = '0;
   logic [31:0] req_time_now = '0;
   logic [5:0] req_slot = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   logic rsp_valid;
   wire outcome_type seen;

   latency_sample_ring_coalescer uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_cmd_seq(req_cmd_seq), .req_cmd_h(req_cmd_h),
      .req_cmd_v(req_cmd_v), .req_cmd_op(req_cmd_op), .req_cmd_arg(req_cmd_arg),
      .req_time_now(req_time_now), .req_slot(req_slot),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_slot_used(seen.slot_used),
      .rsp_took(seen.took), .rsp_box_seq(seen.seq), .rsp_box_arrival(seen.arrival),
      .rsp_box_h(seen.h), .rsp_box_v(seen.v), .rsp_box_op(seen.op),
      .rsp_box_arg(seen.arg), .rsp_box_slot(seen.slot), .rsp_events(seen.events)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Predictor state.
   logic [6:0] ring_size_reg;
   logic [7:0] click_op_reg;
   logic [31:0] e_seq [RING_DEPTH];
   logic [31:0] e_arrival [RING_DEPTH];
   logic [31:0] e_applied_at [RING_DEPTH];
   logic [31:0] e_redrawn_at [RING_DEPTH];
   logic [15:0] e_h [RING_DEPTH];
   logic [15:0] e_v [RING_DEPTH];
   logic [4:0] e_flags [RING_DEPTH];
   logic [15:0] e_carried [RING_DEPTH];
   int unsigned wr_pos, fill;
   logic [31:0] drops, received, applied, coalesced, backwards, redraw_requests, redraws;
   logic [31:0] high_seq, last_apply;
   logic box_full;
   request_type box_req;
   logic [5:0] box_slot;

   outcome_type pending_outcomes [$];
   int mismatches = 0;
   int idle_cycles = 0;
   logic [31:0] seq_counter = 0;
   bit idling_on = 1'b1;

   function automatic void clear_ring();
      for (int i = 0; i < RING_DEPTH; i++) begin
         e_seq[i] = 0; e_arrival[i] = 0; e_applied_at[i] = 0; e_redrawn_at[i] = 0;
         e_h[i] = 0; e_v[i] = 0; e_flags[i] = 0; e_carried[i] = 0;
      end
      wr_pos = 0; fill = 0;
      drops = 0; received = 0; applied = 0; coalesced = 0;
      backwards = 0; redraw_requests = 0; redraws = 0;
      high_seq = 0; last_apply = 0;
      box_full = 0; box_req = '0; box_slot = 0;
   endfunction

   function automatic int unsigned ring_capacity();
      int unsigned c;
      c = ring_size_reg;
      if (c == 0) c = 1;
      if (c > RING_DEPTH) c = RING_DEPTH;
      return c;
   endfunction

   function automatic outcome_type ring_predict(request_type r);
      outcome_type o;
      int unsigned cap, idx, pos, carried;
      logic [4:0] fl;
      o = '0;
      cap = ring_capacity();
      case (r.mode)
         MODE_CLEAR: clear_ring();
         MODE_INTAKE: begin
            idx = (wr_pos < cap) ? wr_pos : 0;
            carried = 0;
            if (box_full) begin
               if (e_seq[box_slot] == box_req.seq) begin
                  e_flags[box_slot] |= FL_COALESCED;
                  carried = e_carried[box_slot] + 1;
                  if (carried > CARRIED_MAX) carried = CARRIED_MAX;
               end else begin
                  carried = 1;
               end
               coalesced++;
               o.events |= EV_COALESCED;
            end
            if (fill >= cap) begin
               drops++;
               o.events |= EV_DROPPED;
            end else begin
               fill++;
            end
            e_seq[idx] = r.seq; e_arrival[idx] = r.now;
            e_applied_at[idx] = 0; e_redrawn_at[idx] = 0;
            e_h[idx] = r.h; e_v[idx] = r.v;
            e_flags[idx] = (r.op == click_op_reg) ? FL_CLICK : 5'd0;
            e_carried[idx] = carried[15:0];
            wr_pos = (idx + 1) % cap;
            received++;
            box_req = r; box_slot = idx[5:0]; box_full = 1;
            o.slot_used = idx[5:0];
         end
         MODE_TAKE: begin
            if (box_full) begin
               o.took = 1; o.seq = box_req.seq; o.arrival = box_req.now;
               o.h = box_req.h; o.v = box_req.v; o.op = box_req.op;
               o.arg = box_req.arg; o.slot = box_slot;
               box_full = 0;
            end
         end
         MODE_APPLY: begin
            fl = FL_APPLIED;
            if (r.seq < high_seq) begin
               backwards++;
               fl |= FL_BACKWARDS;
               o.events |= EV_BACKWARDS;
            end else begin
               high_seq = r.seq;
            end
            if (e_seq[r.slot] == r.seq) begin
               e_applied_at[r.slot] = r.now;
               e_flags[r.slot] |= fl;
               o.events |= EV_STAMPED;
            end
            applied++;
            last_apply = r.now;
         end
         MODE_REDRAW: begin
            pos = (wr_pos < cap) ? wr_pos : 0;
            redraw_requests++;
            for (int i = 1; i <= LOOKBACK && i <= cap; i++) begin
               idx = (pos + cap - i) % cap;
               if (e_flags[idx] & FL_REDRAWN) break;
               if (e_flags[idx] & FL_APPLIED) begin
                  e_redrawn_at[idx] = r.now;
                  e_flags[idx] |= FL_REDRAWN;
                  redraws++;
                  o.events |= EV_REDRAWN;
                  break;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic issue(request_type r, bit typed, outcome_type typed_outcome);
      outcome_type predicted;
      if (idling_on && $urandom_range(99) < 19) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_mode <= r.mode; req_cmd_seq <= r.seq; req_cmd_h <= r.h; req_cmd_v <= r.v;
      req_cmd_op <= r.op; req_cmd_arg <= r.arg; req_time_now <= r.now;
      req_slot <= r.slot;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      idle_cycles = 0;
      predicted = ring_predict(r);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] index, logic [7:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      idle_cycles = 0;
      csr_valid <= 1'b0;
      if (index == CSR_RING_SIZE) ring_size_reg = value[6:0];
      else if (index == CSR_CLICK_OPCODE) click_op_reg = value;
   endtask

   function automatic request_type random_request();
      request_type r;
      int unsigned pick, cap;
      r.seq = $urandom; r.h = $urandom; r.v = $urandom; r.arg = $urandom;
      r.now = $urandom; r.slot = $urandom;
      r.op = ($urandom_range(3) == 0) ? click_op_reg : 8'($urandom);
      cap = ring_capacity();
      pick = $urandom_range(99);
      if (pick < 2) r.mode = MODE_CLEAR;
      else if (pick < 4) r.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else if (pick < 40) r.mode = MODE_INTAKE;
      else if (pick < 60) r.mode = MODE_TAKE;
      else if (pick < 86) r.mode = MODE_APPLY;
      else r.mode = MODE_REDRAW;
      if (r.mode == MODE_INTAKE && $urandom_range(9) != 0) begin
         seq_counter += $urandom_range(1, 3);
         r.seq = seq_counter;
      end
      if (r.mode == MODE_APPLY && $urandom_range(9) < 7) begin
         r.slot = $urandom_range(cap - 1);
         r.seq = e_seq[r.slot];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", seen);
         end else begin
            want = pending_outcomes.pop_front();
            if (seen.slot_used !== want.slot_used || seen.took !== want.took
                || seen.seq !== want.seq || seen.arrival !== want.arrival
                || seen.h !== want.h || seen.v !== want.v || seen.op !== want.op
                || seen.arg !== want.arg || seen.slot !== want.slot
                || seen.events !== want.events) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, seen);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      table_row_type rows [$];
      table_row_type row;
      request_type ones;
      logic [6:0] sizes [9] = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd3, 7'd64, 7'd8, 7'd5};
      logic [7:0] clicks [9] = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd0, 8'd255, 8'd200, 8'd1, 8'd9};

      ring_size_reg = RING_SIZE_RESET;
      click_op_reg = 8'd1;
      clear_ring();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      ones = '1;
      row = '{req: '0, typed: 1, outcome: '0};
      row.req.mode = MODE_TAKE; rows.push_back(row);
      row.req.mode = MODE_UNUSED_LO; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_UNUSED_HI; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_REDRAW; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_INTAKE; row.req.op = 8'd1; rows.push_back(row);
      row.typed = 0;
      row.req = ones; row.req.mode = MODE_INTAKE; row.req.seq = 32'd5; row.req.op = 8'd0;
      rows.push_back(row);
      row.req = '0; row.req.mode = MODE_TAKE; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_TAKE; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_APPLY; row.req.seq = 32'd5; row.req.slot = 6'd1;
      row.req.now = 32'h1234; rows.push_back(row);
      row.req.seq = 32'd3; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_APPLY; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_APPLY; row.req.seq = 32'd0; row.req.slot = 6'd2;
      rows.push_back(row);
      row.req = '0; row.req.mode = MODE_REDRAW; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_REDRAW; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_INTAKE; row.req.seq = 32'd7; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_REDRAW; rows.push_back(row);
      row.req = ones; row.req.mode = MODE_CLEAR; row.typed = 1; row.outcome = '0;
      rows.push_back(row);
      row.req = '0; row.req.mode = MODE_TAKE; rows.push_back(row);
      row.req = '0; row.req.mode = MODE_INTAKE; row.req.now = 32'd9; rows.push_back(row);
      foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].outcome);

      foreach (sizes[p]) begin
         settle();
         write_csr(CSR_RING_SIZE, {1'b0, sizes[p]});
         write_csr(CSR_CLICK_OPCODE, clicks[p]);
         idling_on = (p != 3);
         repeat (215) issue(random_request(), 0, '0);
      end
      settle();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
